// ----- rtl/glmd_pkg.sv -----
// Shared types and constants of the grid local minimum detector.
// Used by every module of the block but glmd_ram; depends on nothing else.
`default_nettype none

package glmd_pkg;

    // Fixed field widths of the stream payloads.
    localparam int HEIGHT_W = 4;
    localparam int POS_W    = 7;
    localparam int MINIMA_W = 15;
    localparam int RISK_W   = 19;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX    = 8'd1;

    // Reset value of both frame dimension registers.
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 8'd100;

    // Decision queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Slots of one job: at most three decisions come from one pixel.
    localparam int SLOTS    = 3;
    localparam int SLOT_N_W = 2;
    localparam logic [SLOT_N_W-1:0] SLOT_FIRST  = 2'd0;
    localparam logic [SLOT_N_W-1:0] SLOT_SECOND = 2'd1;
    localparam logic [SLOT_N_W-1:0] SLOT_THIRD  = 2'd2;

    // One entry of the line store: the two rows above the current one.
    typedef struct packed {
        logic [HEIGHT_W-1:0] older;
        logic [HEIGHT_W-1:0] newer;
    } line_entry_t;

    // One decided pixel, before the totals are applied.
    typedef struct packed {
        logic                done;
        logic                is_min;
        logic [HEIGHT_W-1:0] height;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
    } slot_t;

    // Everything one input pixel asks of the back.
    typedef struct packed {
        logic                clear;
        logic [SLOT_N_W-1:0] count;
        slot_t [SLOTS-1:0]   slot;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_beat_t;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic                frame_done;
        logic                last_of_run;
        logic [RISK_W-1:0]   risk_total;
        logic [MINIMA_W-1:0] minima_total;
        logic                is_minimum;
        logic [HEIGHT_W-1:0] pixel_height;
        logic [POS_W-1:0]    pixel_column;
        logic [POS_W-1:0]    pixel_row;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/glmd_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; holds no reset state.
`default_nettype none

module glmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/glmd_front.sv -----
// Front of the detector: pixel intake, frame position, line store and decisions.
// Depends on glmd_pkg and glmd_ram.
`default_nettype none

module glmd_front #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [glmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [glmd_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [glmd_pkg::QCNT_W-1:0]     q_count,
    output glmd_pkg::job_beat_t                  push_beat
);

    // The 8-bit registers cannot ask for more than 255 pixels.
    localparam int COLS_LIM = (MAX_COLUMNS < 255) ? MAX_COLUMNS : 255;
    localparam int ROWS_LIM = (MAX_ROWS < 255) ? MAX_ROWS : 255;
    localparam int CW = $clog2(COLS_LIM);
    localparam int RW = $clog2(ROWS_LIM);
    localparam int HW = glmd_pkg::HEIGHT_W;

    function automatic logic [CW-1:0] col_last_of(input logic [glmd_pkg::CFG_W-1:0] v);
        logic [CW-1:0] res;
        if (int'(v) < 2)
            res = CW'(1);
        else if (int'(v) > COLS_LIM)
            res = CW'(COLS_LIM - 1);
        else
            res = CW'(int'(v) - 1);
        return res;
    endfunction

    function automatic logic [RW-1:0] row_last_of(input logic [glmd_pkg::CFG_W-1:0] v);
        logic [RW-1:0] res;
        if (int'(v) < 2)
            res = RW'(1);
        else if (int'(v) > ROWS_LIM)
            res = RW'(ROWS_LIM - 1);
        else
            res = RW'(int'(v) - 1);
        return res;
    endfunction

    logic [CW-1:0] col_last_reg;
    logic [RW-1:0] row_last_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [HW-1:0] prev_mid_reg;
    logic [HW-1:0] left_h_reg;
    logic [HW-1:0] left_h2_reg;

    logic          s1_valid_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic [HW-1:0] s1_cur_reg;
    logic [HW-1:0] s1_up_reg;
    logic [HW-1:0] s1_mid_reg;
    logic [HW-1:0] s1_left_reg;
    logic [HW-1:0] s1_lh_reg;
    logic [HW-1:0] s1_lh2_reg;
    logic          s1_last_row_reg;
    logic          s1_last_col_reg;
    logic          s1_clear_reg;

    logic                  accept;
    logic                  cfg_hit;
    logic                  last_col;
    logic                  last_row;
    logic [HW-1:0]         cur;
    logic [CW-1:0]         rd_addr;
    glmd_pkg::line_entry_t ent;
    glmd_pkg::line_entry_t wr_ent;
    logic [glmd_pkg::QCNT_W:0] occupancy;

    assign cur       = s_tdata[HW-1:0];
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == glmd_pkg::CFG_COLUMNS_IDX ||
                                     cfg_index == glmd_pkg::CFG_ROWS_IDX);

    // Room is counted for the job still in the decision stage.
    assign occupancy = {1'b0, q_count} + {{glmd_pkg::QCNT_W{1'b0}}, s1_valid_reg};
    assign s_tready  = occupancy < (glmd_pkg::QCNT_W + 1)'(glmd_pkg::QUEUE_DEPTH);
    assign accept    = s_tvalid && s_tready;

    assign last_col = (col_reg == col_last_reg);
    assign last_row = (row_reg == row_last_reg);

    // Entry c is read one pixel ahead; the last pixel of a row fetches entry 0.
    assign rd_addr = last_col ? '0 : col_reg + CW'(1);
    assign wr_ent  = '{older: ent.newer, newer: cur};

    glmd_ram #(
        .WIDTH ($bits(glmd_pkg::line_entry_t)),
        .DEPTH (COLS_LIM)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (wr_ent),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ent)
    );

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= col_last_of(glmd_pkg::CFG_DIM_RESET);
            row_last_reg <= row_last_of(glmd_pkg::CFG_DIM_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == glmd_pkg::CFG_COLUMNS_IDX)
            begin
                col_last_reg <= col_last_of(cfg_data);
            end
            if (cfg_valid && cfg_index == glmd_pkg::CFG_ROWS_IDX)
            begin
                row_last_reg <= row_last_of(cfg_data);
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // Neighborhood window; payload only, loaded on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_mid_reg    <= ent.newer;
            left_h_reg      <= cur;
            left_h2_reg     <= left_h_reg;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_cur_reg      <= cur;
            s1_up_reg       <= ent.older;
            s1_mid_reg      <= ent.newer;
            s1_left_reg     <= prev_mid_reg;
            s1_lh_reg       <= left_h_reg;
            s1_lh2_reg      <= left_h2_reg;
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
            s1_clear_reg    <= (row_reg == '0) && (col_reg == '0);
        end
    end

    // Decision stage. The right neighbor of the pixel above arrives from the
    // line store in the cycle after the beat, so the tests sit here.
    logic          has_up, has_left, has_left2, has_right;
    logic          dec1, dec2, dec3, in_last;
    logic          d1_min, d2_min, d3_min;
    logic [HW-1:0] right_h;
    logic [RW-1:0] row_above;
    glmd_pkg::job_t job;

    always_comb
    begin
        has_up    = s1_row_reg > RW'(1);
        has_left  = s1_col_reg != '0;
        has_left2 = s1_col_reg > CW'(1);
        has_right = !s1_last_col_reg;
        right_h   = ent.newer;
        row_above = s1_row_reg - RW'(1);

        d1_min = (!has_up || s1_mid_reg < s1_up_reg) && (s1_mid_reg < s1_cur_reg) &&
                 (!has_left || s1_mid_reg < s1_left_reg) &&
                 (!has_right || s1_mid_reg < right_h);
        d2_min = (s1_lh_reg < s1_left_reg) && (s1_lh_reg < s1_cur_reg) &&
                 (!has_left2 || s1_lh_reg < s1_lh2_reg);
        d3_min = (s1_cur_reg < s1_mid_reg) && (s1_cur_reg < s1_lh_reg);

        in_last = (s1_row_reg != '0) && s1_last_row_reg;
        dec1    = s1_row_reg != '0;
        dec2    = in_last && has_left;
        dec3    = in_last && s1_last_col_reg;

        job.clear = s1_clear_reg;
        if (dec3)
            job.count = 2'd3;
        else if (dec2)
            job.count = 2'd2;
        else if (dec1)
            job.count = 2'd1;
        else
            job.count = 2'd0;

        job.slot[0] = '{done: 1'b0, is_min: d1_min, height: s1_mid_reg,
                        col: glmd_pkg::POS_W'(s1_col_reg),
                        row: glmd_pkg::POS_W'(row_above)};
        job.slot[1] = '{done: 1'b0, is_min: d2_min, height: s1_lh_reg,
                        col: glmd_pkg::POS_W'(s1_col_reg - CW'(1)),
                        row: glmd_pkg::POS_W'(s1_row_reg)};
        job.slot[2] = '{done: 1'b1, is_min: d3_min, height: s1_cur_reg,
                        col: glmd_pkg::POS_W'(s1_col_reg),
                        row: glmd_pkg::POS_W'(s1_row_reg)};

        push_beat.valid = s1_valid_reg && (job.count != 2'd0 || job.clear);
        push_beat.job   = job;
    end

endmodule

`default_nettype wire

// ----- rtl/glmd_queue.sv -----
// Short job queue that decouples the front from the back.
// Depends on glmd_pkg.
`default_nettype none

module glmd_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire glmd_pkg::job_beat_t         push_beat,
    input  wire logic                        pop,
    output glmd_pkg::job_beat_t              head,
    output logic [glmd_pkg::QCNT_W-1:0]      count
);

    glmd_pkg::job_t                  mem [glmd_pkg::QUEUE_DEPTH];
    logic [glmd_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [glmd_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push_beat.valid && !do_pop)
            count_next = count_reg + glmd_pkg::QCNT_W'(1);
        else if (!push_beat.valid && do_pop)
            count_next = count_reg - glmd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_beat.valid)
                wr_ptr_reg <= wr_ptr_reg + glmd_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + glmd_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_beat.valid)
            mem[wr_ptr_reg] <= push_beat.job;
    end

    assign head.valid = count_reg != '0;
    assign head.job   = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

// ----- rtl/glmd_back.sv -----
// Back of the detector: expands jobs into result beats and keeps the totals.
// Depends on glmd_pkg.
`default_nettype none

module glmd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire glmd_pkg::job_beat_t  head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output glmd_pkg::result_t         out_beat
);

    logic [glmd_pkg::SLOT_N_W-1:0] k_reg, k_next;
    logic [glmd_pkg::MINIMA_W-1:0] minima_reg, minima_next;
    logic [glmd_pkg::RISK_W-1:0]   risk_reg, risk_next;
    logic                          out_valid_reg, out_valid_next;
    glmd_pkg::result_t             out_reg, out_next;

    glmd_pkg::slot_t               slot;
    logic                          room;
    logic                          take;
    logic                          last_slot;
    logic                          empty_job;
    logic [glmd_pkg::MINIMA_W-1:0] minima_base;
    logic [glmd_pkg::RISK_W-1:0]   risk_base;

    assign room      = !out_valid_reg || out_ready;
    assign take      = head.valid && room;
    assign empty_job = head.job.count == 2'd0;
    assign last_slot = (k_reg + glmd_pkg::SLOT_N_W'(1)) == head.job.count;

    always_comb
    begin
        case (k_reg)
            glmd_pkg::SLOT_FIRST:  slot = head.job.slot[0];
            glmd_pkg::SLOT_SECOND: slot = head.job.slot[1];
            glmd_pkg::SLOT_THIRD:  slot = head.job.slot[2];
            default:               slot = head.job.slot[0];
        endcase
    end

    always_comb
    begin
        // Totals restart on the first decision of a frame.
        if (k_reg == glmd_pkg::SLOT_FIRST && head.job.clear)
        begin
            minima_base = '0;
            risk_base   = '0;
        end
        else
        begin
            minima_base = minima_reg;
            risk_base   = risk_reg;
        end

        minima_next    = minima_reg;
        risk_next      = risk_reg;
        k_next         = k_reg;
        pop            = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (take && empty_job)
        begin
            // A clear-only job from the first pixel of a frame.
            minima_next = minima_base;
            risk_next   = risk_base;
            pop         = 1'b1;
        end
        else if (take)
        begin
            if (slot.is_min)
            begin
                minima_next = minima_base + glmd_pkg::MINIMA_W'(1);
                risk_next   = risk_base + glmd_pkg::RISK_W'(slot.height) +
                              glmd_pkg::RISK_W'(1);
            end
            else
            begin
                minima_next = minima_base;
                risk_next   = risk_base;
            end
            out_next.pixel_row    = slot.row;
            out_next.pixel_column = slot.col;
            out_next.pixel_height = slot.height;
            out_next.is_minimum   = slot.is_min;
            out_next.minima_total = minima_next;
            out_next.risk_total   = risk_next;
            out_next.last_of_run  = last_slot;
            out_next.frame_done   = slot.done;
            out_valid_next        = 1'b1;
            if (last_slot)
            begin
                pop    = 1'b1;
                k_next = glmd_pkg::SLOT_FIRST;
            end
            else
            begin
                k_next = k_reg + glmd_pkg::SLOT_N_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= glmd_pkg::SLOT_FIRST;
            minima_reg    <= '0;
            risk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            minima_reg    <= minima_next;
            risk_reg      <= risk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/grid_local_minimum_detector_unit.sv -----
// Throughput: one pixel beat per cycle while the queue has room. The first row gives no
// results, later rows one per beat, the last row two (one on its first pixel, three on
// the final pixel); the single result register drains one result per cycle while m_tready
// is high, so the last row is held to the drain rate through a four-job queue.
// Reset: positions, queue, totals and output clear; both dimensions return to 100.
// The line store is not cleared, since only entries written in the current frame are read.
`default_nettype none

module grid_local_minimum_detector_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 128
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Pixel stream in.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [3:0] height, [7:4] zero
    // Result stream out.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata from bit 0: pixel_row[6:0], pixel_column[13:7], pixel_height[17:14],
    // is_minimum[18], minima_total[33:19], risk_total[52:34], zero fill [55:53].
    output logic [55:0]                          m_tdata,
    output logic                                 m_tlast,   // last result of the beat
    output logic                                 m_tuser,   // frame_done
    // Configuration writes: index 0 columns_in_use, index 1 rows_in_use.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [glmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [glmd_pkg::CFG_W-1:0]      cfg_data
);

    // The front takes pixels, tracks the frame position and keeps the two
    // earlier rows in one line store, each entry holding both rows of a column.
    // A decision stage behind it forms up to three verdicts per pixel and
    // hands them as one job to the queue. The back turns each job into result
    // beats and keeps the running totals. The front stops taking pixels when the
    // queue, with the job still in the decision stage counted, has no free entry.

    glmd_pkg::job_beat_t          push_beat;
    glmd_pkg::job_beat_t          head;
    logic [glmd_pkg::QCNT_W-1:0]  q_count;
    logic                         pop;
    glmd_pkg::result_t            out_beat;

    glmd_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .push_beat (push_beat)
    );

    glmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_beat (push_beat),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    glmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    assign m_tdata = {3'b000, out_beat.risk_total, out_beat.minima_total,
                      out_beat.is_minimum, out_beat.pixel_height,
                      out_beat.pixel_column, out_beat.pixel_row};
    assign m_tlast = out_beat.last_of_run;
    assign m_tuser = out_beat.frame_done;

`ifndef SYNTHESIS
    // A job is never pushed into a full queue unless one leaves in the same cycle.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_beat.valid |->
            (q_count < glmd_pkg::QCNT_W'(glmd_pkg::QUEUE_DEPTH) || pop))
        else $error("job pushed into a full queue");

    // The result that closes a frame is always the last one of its beat.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame_done result is not the last of its beat");

    // A new result appears only when a job was waiting in the queue.
    a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(head.valid))
        else $error("result produced without a queued job");
`endif

endmodule

`default_nettype wire
